// ===== rtl/sott_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted offset translation table package
// Shared widths, operation and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package sott_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 1024;
  localparam int DEFAULT_OFFSET_BITS = 35;
  localparam int DEFAULT_COUNT_BITS  = $clog2(DEFAULT_TABLE_DEPTH + 1);

  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 3;

  typedef enum logic [OP_BITS-1:0] {
    OP_APPEND = 2'd0,
    OP_POP    = 2'd1,
    OP_LOOKUP = 2'd2
  } sott_op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK    = 3'd0,
    STATUS_FULL  = 3'd1,
    STATUS_MISS  = 3'd2,
    STATUS_EMPTY = 3'd3,
    STATUS_ORDER = 3'd4
  } sott_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPEND_CHK,
    ST_SEARCH,
    ST_FINISH
  } sott_state_t;

endpackage

// ===== rtl/sott_in_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one table operation per transfer.
// ----------------------------------------------------------------------------
interface sott_in_if #(
  parameter int OFFSET_BITS = sott_pkg::DEFAULT_OFFSET_BITS
);
  import sott_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OP_BITS-1:0]     op;
  logic [OFFSET_BITS-1:0] source_offset;
  logic [OFFSET_BITS-1:0] target_offset;

  modport source (output valid, op, source_offset, target_offset, input ready);
  modport sink   (input valid, op, source_offset, target_offset, output ready);
endinterface

// ===== rtl/sott_out_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one operation result per transfer.
// ----------------------------------------------------------------------------
interface sott_out_if #(
  parameter int OFFSET_BITS = sott_pkg::DEFAULT_OFFSET_BITS,
  parameter int COUNT_BITS  = sott_pkg::DEFAULT_COUNT_BITS
);
  import sott_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [OFFSET_BITS-1:0] mapped_offset;
  logic [COUNT_BITS-1:0]  entries_used;

  modport source (output valid, status, mapped_offset, entries_used, input ready);
  modport sink   (input valid, status, mapped_offset, entries_used, output ready);
endinterface

// ===== rtl/sott_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sott_ram #(
  parameter int WIDTH = 2 * sott_pkg::DEFAULT_OFFSET_BITS,
  parameter int DEPTH = sott_pkg::DEFAULT_TABLE_DEPTH,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sorted_offset_translation_table.sv =====
// ----------------------------------------------------------------------------
// Sorted offset translation table
// Append-only source-to-target offset map with binary-search lookup.
// ----------------------------------------------------------------------------
// Each request transfer carries one operation: append a (source, target)
// pair, remove the last pair, or look up a source offset. Appends must arrive
// in strictly increasing source order; the table rejects an append to a full
// table (full wins over order) and an out-of-order append, a remove from an
// empty table, and a lookup miss, each with its own status code. Every request
// yields exactly one response carrying the status, the found target offset
// (zero unless a lookup hit) and the entry count after the operation. The
// block handles one request at a time and drops ready while it works. A
// remove, a lookup on an empty table or an append to an empty or full table
// goes straight to the finish state; any other append first reads the last
// source from the RAM to check ordering, and any other lookup runs a binary
// search in which the single RAM read port supplies one probe per cycle.
// A new request is accepted while the previous response still waits in the
// output register. The pair RAM has no reset and no clearing pass; only
// entries below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_offset_translation_table #(
  parameter int TABLE_DEPTH = sott_pkg::DEFAULT_TABLE_DEPTH,
  parameter int OFFSET_BITS = sott_pkg::DEFAULT_OFFSET_BITS
) (
  input logic       clk,
  input logic       rst,
  sott_in_if.sink   in_ch,
  sott_out_if.source out_ch
);
  import sott_pkg::*;

  localparam int IDX_BITS   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(TABLE_DEPTH + 1);
  localparam int PAIR_BITS  = 2 * OFFSET_BITS;

  // Sequencer and entry count.
  sott_state_t state, state_next;
  logic [COUNT_BITS-1:0] count, count_next;

  // Operation operands captured at accept.
  logic [OFFSET_BITS-1:0] key, key_next;
  logic [OFFSET_BITS-1:0] tgt, tgt_next;

  // Binary search window [lo, hi) and the index of the probe in flight.
  logic [COUNT_BITS-1:0] lo, lo_next;
  logic [COUNT_BITS-1:0] hi, hi_next;
  logic [IDX_BITS-1:0]   mid, mid_next;

  // The entry at hi is the latest probe that was not below the key; keep
  // whether it matched and its target so no extra read is needed at the end.
  logic                   cand_hit, cand_hit_next;
  logic [OFFSET_BITS-1:0] cand_tgt, cand_tgt_next;

  // Result waiting for the output register.
  sott_status_t           res_status, res_status_next;
  logic [OFFSET_BITS-1:0] res_mapped, res_mapped_next;

  // Output register.
  logic                   out_valid;
  sott_status_t           out_status;
  logic [OFFSET_BITS-1:0] out_mapped;
  logic [COUNT_BITS-1:0]  out_count;
  logic                   out_load;

  // Pair RAM ports.
  logic                   ram_we;
  logic [IDX_BITS-1:0]    ram_waddr;
  logic [PAIR_BITS-1:0]   ram_wdata;
  logic [IDX_BITS-1:0]    ram_raddr;
  logic [PAIR_BITS-1:0]   ram_rdata;
  logic [OFFSET_BITS-1:0] rd_src;
  logic [OFFSET_BITS-1:0] rd_tgt;

  logic                  in_xfer;
  logic                  below;
  logic [COUNT_BITS-1:0] win_lo;
  logic [COUNT_BITS-1:0] win_hi;
  logic [COUNT_BITS-1:0] win_mid;
  logic                  table_full;

  sott_ram #(
    .WIDTH (PAIR_BITS),
    .DEPTH (TABLE_DEPTH),
    .ADDR_BITS (IDX_BITS)
  ) u_pair_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_src = ram_rdata[PAIR_BITS-1:OFFSET_BITS];
  assign rd_tgt = ram_rdata[OFFSET_BITS-1:0];

  assign in_ch.ready = (state == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign table_full  = (count == COUNT_BITS'(TABLE_DEPTH));

  // One search step: the probe result narrows the window, and the midpoint of
  // the new window is the next read address.
  assign below   = (rd_src < key);
  assign win_lo  = below ? (COUNT_BITS'(mid) + COUNT_BITS'(1)) : lo;
  assign win_hi  = below ? hi : COUNT_BITS'(mid);
  assign win_mid = win_lo + ((win_hi - win_lo) >> 1);

  // Appends always land at the current end of the table.
  assign ram_waddr = count[IDX_BITS-1:0];
  assign ram_wdata = (state == ST_IDLE) ? {in_ch.source_offset, in_ch.target_offset}
                                        : {key, tgt};

  assign out_load = (state == ST_FINISH) && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key        <= key_next;
    tgt        <= tgt_next;
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    cand_hit   <= cand_hit_next;
    cand_tgt   <= cand_tgt_next;
    res_status <= res_status_next;
    res_mapped <= res_mapped_next;
    if (out_load) begin
      out_status <= res_status;
      out_mapped <= res_mapped;
      out_count  <= count;
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    key_next        = key;
    tgt_next        = tgt;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    cand_hit_next   = cand_hit;
    cand_tgt_next   = cand_tgt;
    res_status_next = res_status;
    res_mapped_next = res_mapped;
    ram_we          = 1'b0;
    ram_raddr       = mid;

    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          key_next        = in_ch.source_offset;
          tgt_next        = in_ch.target_offset;
          res_status_next = STATUS_OK;
          res_mapped_next = '0;
          state_next      = ST_FINISH;
          case (in_ch.op)
            OP_APPEND: begin
              if (table_full) begin
                res_status_next = STATUS_FULL;
              end else if (count == '0) begin
                ram_we     = 1'b1;
                count_next = count + COUNT_BITS'(1);
              end else begin
                // Fetch the last source to check ordering.
                ram_raddr  = IDX_BITS'(count - COUNT_BITS'(1));
                state_next = ST_APPEND_CHK;
              end
            end
            OP_POP: begin
              if (count == '0) begin
                res_status_next = STATUS_EMPTY;
              end else begin
                count_next = count - COUNT_BITS'(1);
              end
            end
            OP_LOOKUP: begin
              if (count == '0) begin
                res_status_next = STATUS_MISS;
              end else begin
                lo_next       = '0;
                hi_next       = count;
                cand_hit_next = 1'b0;
                cand_tgt_next = '0;
                mid_next      = IDX_BITS'(count >> 1);
                ram_raddr     = IDX_BITS'(count >> 1);
                state_next    = ST_SEARCH;
              end
            end
            default: begin
              // The unused code does nothing and reports success.
              res_status_next = STATUS_OK;
            end
          endcase
        end
      end

      ST_APPEND_CHK: begin
        if (rd_src >= key) begin
          res_status_next = STATUS_ORDER;
        end else begin
          ram_we     = 1'b1;
          count_next = count + COUNT_BITS'(1);
        end
        state_next = ST_FINISH;
      end

      ST_SEARCH: begin
        lo_next = win_lo;
        hi_next = win_hi;
        if (!below) begin
          cand_hit_next = (rd_src == key);
          cand_tgt_next = rd_tgt;
        end
        if (win_lo < win_hi) begin
          mid_next  = IDX_BITS'(win_mid);
          ram_raddr = IDX_BITS'(win_mid);
        end else begin
          // Window closed: the answer is the entry at hi, if any was probed.
          if (!below && (rd_src == key)) begin
            res_status_next = STATUS_OK;
            res_mapped_next = rd_tgt;
          end else if (below && cand_hit) begin
            res_status_next = STATUS_OK;
            res_mapped_next = cand_tgt;
          end else begin
            res_status_next = STATUS_MISS;
            res_mapped_next = '0;
          end
          state_next = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.status        = out_status;
  assign out_ch.mapped_offset = out_mapped;
  assign out_ch.entries_used  = out_count;

  // The entry count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // A remove from a non-empty table drops exactly one entry.
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (in_ch.op == OP_POP) && (count != '0)) |=>
      (count == $past(count) - COUNT_BITS'(1)))
    else $error("remove did not drop one entry");

  // The search window stays open while probes are in flight.
  a_search_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> ((lo < hi) && (COUNT_BITS'(mid) >= lo) &&
                              (COUNT_BITS'(mid) < hi)))
    else $error("search probe outside its window");

  // Only a successful operation can carry a nonzero mapped offset.
  a_mapped_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != STATUS_OK)) |-> (out_mapped == '0))
    else $error("failed operation reports a mapped offset");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted offset translation table testbench
// Drives append, remove and lookup requests through the request channel and
// checks every response against an in-bench model of the table or against a
// typed expectation, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import sott_pkg::*;

  localparam int DEPTH = DEFAULT_TABLE_DEPTH;
  localparam int OFS   = DEFAULT_OFFSET_BITS;
  localparam int CNT   = DEFAULT_COUNT_BITS;

  // The op field has one code that the block treats as a no-op.
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

  localparam logic [OFS-1:0] OFS_MAX = '1;

  // Random stimulus stops once this many requests have been transferred.
  // The table gets filled to the top once, after FILL_AFTER requests.
  localparam int ITEM_TARGET = 1750;
  localparam int FILL_AFTER  = 500;

  // Clock edges that run after the last expected response has been checked.
  localparam int TAIL_CYCLES = 30;

  // One response as the block should produce it.
  typedef struct packed {
    sott_status_t   status;
    logic [OFS-1:0] mapped;
    logic [CNT-1:0] used;
  } table_result_t;

  // One row of the directed table. When known is set, the expected response
  // is the one typed into the row; otherwise it comes from the table model.
  typedef struct {
    logic [OP_BITS-1:0] op;
    logic [OFS-1:0]     src;
    logic [OFS-1:0]     dst;
    bit                 known;
    table_result_t      res;
  } dir_row_t;

  logic clk;
  logic rst;

  sott_in_if  #(.OFFSET_BITS(OFS))                  in_ch ();
  sott_out_if #(.OFFSET_BITS(OFS), .COUNT_BITS(CNT)) out_ch ();

  sorted_offset_translation_table #(
    .TABLE_DEPTH(DEPTH),
    .OFFSET_BITS(OFS)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // --------------------------------------------------------------------------
  // Table model. It holds its own copy of the pair store and the entry count,
  // and is advanced once for every request transfer, in transfer order.
  // --------------------------------------------------------------------------
  logic [OFS-1:0] src_tab [DEPTH];
  logic [OFS-1:0] dst_tab [DEPTH];
  int unsigned    entry_cnt = 0;

  // Responses still owed by the block, oldest first.
  table_result_t pending_results [$];

  int  mismatch_count = 0;
  int  items_sent     = 0;
  // While quiet is set, neither side inserts gaps or stalls.
  bit  quiet          = 1'b0;
  int  ready_hold     = 0;

  function automatic table_result_t apply_table_op(logic [OP_BITS-1:0] op,
                                                   logic [OFS-1:0] src,
                                                   logic [OFS-1:0] dst);
    table_result_t r;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    r.status = STATUS_OK;
    r.mapped = '0;
    case (op)
      OP_APPEND: begin
        // A full table wins over an out-of-order source.
        if (entry_cnt >= DEPTH) begin
          r.status = STATUS_FULL;
        end else if (entry_cnt > 0 && src <= src_tab[entry_cnt-1]) begin
          r.status = STATUS_ORDER;
        end else begin
          src_tab[entry_cnt] = src;
          dst_tab[entry_cnt] = dst;
          entry_cnt++;
        end
      end
      OP_POP: begin
        // Removed pairs stay in the store; they just fall out of the count.
        if (entry_cnt == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          entry_cnt--;
        end
      end
      OP_LOOKUP: begin
        // Lower-bound search over the held entries, then an exact-match test.
        lo = 0;
        hi = entry_cnt;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (src_tab[mid] < src) begin
            lo = mid + 1;
          end else begin
            hi = mid;
          end
        end
        if (lo < entry_cnt && src_tab[lo] == src) begin
          r.mapped = dst_tab[lo];
        end else begin
          r.status = STATUS_MISS;
        end
      end
      default: begin
      end
    endcase
    r.used = CNT'(entry_cnt);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers.
  // --------------------------------------------------------------------------
  function automatic logic [OFS-1:0] rand_offset();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[OFS-1:0];
  endfunction

  // Idle cycles before a request or length of a response stall: mostly none
  // or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // A source strictly above the last held one, unless the top of the offset
  // range is reached, in which case the maximum is returned (and an append
  // of it is then out of order).
  function automatic logic [OFS-1:0] next_source();
    logic [63:0] cand;
    int r;
    r = $urandom_range(0, 99);
    if (entry_cnt == 0) begin
      if (r < 70) begin
        return OFS'($urandom_range(0, 1 << 16));
      end
      return rand_offset();
    end
    cand = 64'(src_tab[entry_cnt-1]);
    if (r < 70) begin
      cand = cand + $urandom_range(1, 64);
    end else if (r < 95) begin
      cand = cand + $urandom_range(1, 1 << 20);
    end else begin
      cand = cand + 64'($urandom()) + 64'd1;
    end
    if (cand > 64'(OFS_MAX)) begin
      return OFS_MAX;
    end
    return cand[OFS-1:0];
  endfunction

  // Lookup keys: mostly a held source, some next to one, the rest anywhere.
  function automatic logic [OFS-1:0] lookup_key();
    logic [OFS-1:0] held;
    int r;
    r = $urandom_range(0, 99);
    if (entry_cnt == 0 || r >= 85) begin
      return rand_offset();
    end
    held = src_tab[$urandom_range(0, entry_cnt - 1)];
    if (r < 70) begin
      return held;
    end else if (r < 78) begin
      return held + 1'b1;
    end
    return held - 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Request side. The valid line is only lowered when a gap follows, so that
  // back-to-back requests keep it high without a second assignment in the
  // same time step. Ready is sampled at the edge, before the block updates it.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [OP_BITS-1:0] op, input logic [OFS-1:0] src,
                              input logic [OFS-1:0] dst, input bit known,
                              input table_result_t typed_res);
    int idle;
    table_result_t res;
    idle = pick_gap();
    if (idle > 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.source_offset <= src;
    in_ch.target_offset <= dst;
    do @(posedge clk); while (!in_ch.ready);
    // The model advances on every transfer, even where the row types in
    // its own expectation.
    res = apply_table_op(op, src, dst);
    if (known) begin
      res = typed_res;
    end
    pending_results = {pending_results, res};
    items_sent++;
  endtask

  task automatic send_op(input logic [OP_BITS-1:0] op, input logic [OFS-1:0] src,
                         input logic [OFS-1:0] dst);
    send_request(op, src, dst, 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Directed table. It walks the empty-table cases, the extremes of the
  // offset range, both kinds of out-of-order append, hit and miss lookups,
  // removal and reuse of the last slot, and the unused op code.
  // --------------------------------------------------------------------------
  dir_row_t dir_tab [25] = '{
    // Empty table: lookups miss, remove reports empty, no-op is harmless.
    '{OP_LOOKUP, 35'd0,           35'd0,           1'b1, '{STATUS_MISS,  35'd0, 11'd0}},
    '{OP_LOOKUP, OFS_MAX,         35'd0,           1'b1, '{STATUS_MISS,  35'd0, 11'd0}},
    '{OP_POP,    35'd0,           35'd0,           1'b1, '{STATUS_EMPTY, 35'd0, 11'd0}},
    '{OP_UNUSED, OFS_MAX,         OFS_MAX,         1'b1, '{STATUS_OK,    35'd0, 11'd0}},
    // Lowest source with the highest target, then a duplicate of it.
    '{OP_APPEND, 35'd0,           OFS_MAX,         1'b1, '{STATUS_OK,    35'd0, 11'd1}},
    '{OP_APPEND, 35'd0,           35'd5,           1'b1, '{STATUS_ORDER, 35'd0, 11'd1}},
    '{OP_LOOKUP, 35'd0,           35'd0,           1'b1, '{STATUS_OK,  OFS_MAX, 11'd1}},
    // Alternating bit patterns, then a source just below the last one.
    '{OP_APPEND, 35'h2_AAAA_AAAA, 35'h5_5555_5555, 1'b1, '{STATUS_OK,    35'd0, 11'd2}},
    '{OP_APPEND, 35'h2_AAAA_AAA9, 35'd0,           1'b1, '{STATUS_ORDER, 35'd0, 11'd2}},
    // Highest source with target zero: a hit must still return zero.
    '{OP_APPEND, OFS_MAX,         35'd0,           1'b1, '{STATUS_OK,    35'd0, 11'd3}},
    '{OP_LOOKUP, 35'h2_AAAA_AAAA, 35'd0,    1'b1, '{STATUS_OK, 35'h5_5555_5555, 11'd3}},
    '{OP_LOOKUP, OFS_MAX,         35'd0,           1'b1, '{STATUS_OK,    35'd0, 11'd3}},
    '{OP_LOOKUP, OFS_MAX - 1'b1,  35'd0,           1'b1, '{STATUS_MISS,  35'd0, 11'd3}},
    '{OP_LOOKUP, 35'd1,           35'd0,           1'b1, '{STATUS_MISS,  35'd0, 11'd3}},
    // Equal to the last source at the top of the range.
    '{OP_APPEND, OFS_MAX,         35'd7,           1'b1, '{STATUS_ORDER, 35'd0, 11'd3}},
    '{OP_UNUSED, 35'd0,           35'd0,           1'b1, '{STATUS_OK,    35'd0, 11'd3}},
    // Remove the top entry; it must no longer be found, and its slot is
    // reused by the next append.
    '{OP_POP,    35'd0,           35'd0,           1'b1, '{STATUS_OK,    35'd0, 11'd2}},
    '{OP_LOOKUP, OFS_MAX,         35'd0,           1'b1, '{STATUS_MISS,  35'd0, 11'd2}},
    '{OP_APPEND, 35'h4_0000_0000, 35'h1_2345_6789, 1'b0, '{STATUS_OK,    35'd0, 11'd0}},
    '{OP_LOOKUP, 35'h4_0000_0000, 35'd0,           1'b0, '{STATUS_OK,    35'd0, 11'd0}},
    // Drain to empty and one remove past it.
    '{OP_POP,    35'd0,           35'd0,           1'b1, '{STATUS_OK,    35'd0, 11'd2}},
    '{OP_POP,    35'd0,           35'd0,           1'b1, '{STATUS_OK,    35'd0, 11'd1}},
    '{OP_POP,    35'd0,           35'd0,           1'b1, '{STATUS_OK,    35'd0, 11'd0}},
    '{OP_POP,    35'd0,           35'd0,           1'b1, '{STATUS_EMPTY, 35'd0, 11'd0}},
    // Pairs left behind in the store are not visible to a lookup.
    '{OP_LOOKUP, 35'd0,           35'd0,           1'b1, '{STATUS_MISS,  35'd0, 11'd0}}
  };

  // --------------------------------------------------------------------------
  // Clock, reset and stimulus.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    logic [63:0]    fill_src;
    logic [OFS-1:0] src;
    logic [OFS-1:0] last;
    int             burst_len;
    int             r;
    bit             filled;
    filled = 1'b0;

    rst                 <= 1'b1;
    in_ch.valid         <= 1'b0;
    in_ch.op            <= OP_APPEND;
    in_ch.source_offset <= '0;
    in_ch.target_offset <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      send_request(dir_tab[i].op, dir_tab[i].src, dir_tab[i].dst, dir_tab[i].known,
                   dir_tab[i].res);
    end

    // Random part, in bursts. Each burst may run without gaps or stalls.
    while (items_sent < ITEM_TARGET) begin
      quiet = ($urandom_range(0, 9) == 0);
      if (!filled && items_sent >= FILL_AFTER) begin
        // Empty the table, then append ascending sources until it is full.
        // Steps stay small enough that 1024 of them fit in the offset range.
        filled = 1'b1;
        while (entry_cnt > 0) begin
          send_op(OP_POP, rand_offset(), rand_offset());
        end
        fill_src = 64'($urandom_range(0, 1 << 20));
        while (entry_cnt < DEPTH) begin
          send_op(OP_APPEND, fill_src[OFS-1:0], rand_offset());
          fill_src = fill_src + $urandom_range(1, 1 << 24);
        end
        // On the full table: appends in and out of order are both rejected
        // as full, and lookups run the longest search.
        for (int k = 0; k < 6; k++) begin
          send_op(OP_APPEND, (k % 2 == 0) ? OFS_MAX : rand_offset(), rand_offset());
        end
        for (int k = 0; k < 30; k++) begin
          send_op(OP_LOOKUP, lookup_key(), rand_offset());
        end
        for (int k = 0; k < 3; k++) begin
          send_op(OP_POP, rand_offset(), rand_offset());
        end
        for (int k = 0; k < 2; k++) begin
          send_op(OP_APPEND, next_source(), rand_offset());
        end
      end else if (entry_cnt > 0 && entry_cnt < 64 && $urandom_range(0, 9) == 0) begin
        // Now and then run a small table dry and poke at the empty state.
        while (entry_cnt > 0) begin
          send_op(OP_POP, rand_offset(), rand_offset());
        end
        send_op(OP_POP, rand_offset(), rand_offset());
        send_op(OP_LOOKUP, rand_offset(), rand_offset());
      end else begin
        // Mixed traffic: mostly in-order appends and lookups of held keys,
        // with removes, rejected appends and the unused op code mixed in.
        burst_len = $urandom_range(10, 40);
        for (int k = 0; k < burst_len; k++) begin
          r = $urandom_range(0, 99);
          if (r < 45) begin
            src = next_source();
            if (entry_cnt > 0 && $urandom_range(0, 9) == 0) begin
              last = src_tab[entry_cnt-1];
              case ($urandom_range(0, 2))
                0: src = last;
                1: src = (last > 1000) ? last - OFS'($urandom_range(1, 1000)) : '0;
                default: src = OFS'(64'(rand_offset()) % (64'(last) + 64'd1));
              endcase
            end
            send_op(OP_APPEND, src, rand_offset());
          end else if (r < 80) begin
            send_op(OP_LOOKUP, lookup_key(), rand_offset());
          end else if (r < 95) begin
            send_op(OP_POP, rand_offset(), rand_offset());
          end else begin
            send_op(OP_UNUSED, rand_offset(), rand_offset());
          end
        end
      end
    end

    in_ch.valid <= 1'b0;
    quiet = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Response side: random stalls on ready, and a field-by-field check of each
  // response transfer against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    table_result_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("response transfer with no request outstanding");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_ch.status);
          mismatch_count++;
        end
        if (out_ch.mapped_offset !== want.mapped) begin
          $error("mapped_offset: expected 0x%0h, actual 0x%0h", want.mapped,
                 out_ch.mapped_offset);
          mismatch_count++;
        end
        if (out_ch.entries_used !== want.used) begin
          $error("entries_used: expected %0d, actual %0d", want.used, out_ch.entries_used);
          mismatch_count++;
        end
      end
    end
    if (quiet) begin
      ready_hold = 0;
      out_ch.ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
      out_ch.ready <= 1'b0;
    end else begin
      ready_hold = pick_gap();
      out_ch.ready <= (ready_hold == 0);
      if (ready_hold > 0) begin
        ready_hold--;
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #(64'd20_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
